/* rtl/core/adiftt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adiftt_pkg
// Shared types and constants for the ADIF tag tokenizer.
// ----------------------------------------------------------------------------
package adiftt_pkg;

    localparam int NAME_CAP  = 19;
    localparam int VALUE_CAP = 19;
    localparam int LEN_W     = 16;
    localparam int FLEN_W    = 16;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 5;
    localparam int EV_W      = 4;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_NAME   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_TYPE   = 3'd3,
        PH_VALUE  = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 4'd0,
        EV_NAME     = 4'd1,
        EV_VALUE    = 4'd2,
        EV_DONE     = 4'd3,
        EV_DROP     = 4'd4,
        EV_EOR      = 4'd5,
        EV_EOH      = 4'd6,
        EV_ERROR    = 4'd7,
        EV_RESYNC   = 4'd8,
        EV_LONGNAME = 4'd9
    } t_event;

    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] up;
        logic       is_lt;
        logic       is_gt;
        logic       is_colon;
        logic       is_digit;
        logic [3:0] digit;
    } t_tok;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

/* rtl/core/adiftt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adiftt_in_if / adiftt_out_if
// Byte input and event output channels of the ADIF tag tokenizer.
// ----------------------------------------------------------------------------
interface adiftt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface adiftt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [7:0]  out_byte;
    logic [4:0]  byte_index;
    logic [15:0] field_length;

    modport source (output valid, output event_res, output out_byte,
                    output byte_index, output field_length, input ready);
    modport sink   (input valid, input event_res, input out_byte,
                    input byte_index, input field_length, output ready);
endinterface

/* rtl/core/adif_tag_tokenizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adif_tag_tokenizer_top
// Byte-serial ADIF tag tokenizer: one event word per input byte.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one character word per handshake (valid/ready). o_out
//   carries one event word for every accepted character: event code, echoed
//   byte, byte index within name or value, and declared field length.
//   A front stage classifies each character and pushes it into a two-entry
//   queue; the back stage runs the tag state machine and loads a registered
//   output. The event for a character passes through a queue entry and then
//   the output register before it is presented; one word per cycle is
//   sustained while the receiver keeps ready high.
//   When the receiver stalls, the output word holds, the back stage stops
//   popping, and the queue fills; input ready drops once both queue entries
//   are occupied and rises again as soon as one drains.
//   Synchronous active-low reset empties the queue and the output register
//   and returns the parser to searching for an opening bracket.
// ----------------------------------------------------------------------------
module adif_tag_tokenizer_top
    import adiftt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    adiftt_in_if.sink    i_in,
    adiftt_out_if.source o_out
);

    t_hs  push;
    t_tok front_tok;
    t_tok q_tok;
    logic q_ready;
    logic q_valid;
    logic pop;

    adiftt_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_tok     (front_tok)
    );

    adiftt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (front_tok),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_tok   (q_tok)
    );

    adiftt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tok     (q_tok),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* rtl/core/adiftt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adiftt_front
// Accepts input words and classifies each character for the parser.
// ----------------------------------------------------------------------------
module adiftt_front
    import adiftt_pkg::*;
(
    adiftt_in_if.sink i_in,
    input  logic      i_q_ready,
    output t_hs       o_push,
    output t_tok      o_tok
);

    logic [7:0] c;

    assign c = i_in.in_byte;
    assign i_in.ready   = i_q_ready;
    assign o_push.valid = i_in.valid && i_q_ready;
    assign o_push.ready = i_q_ready;

    always_comb begin
        o_tok.raw      = c;
        o_tok.up       = (c >= CH_LO_A && c <= CH_LO_Z) ? (c - CASE_OFS) : c;
        o_tok.is_lt    = (c == CH_LT);
        o_tok.is_gt    = (c == CH_GT);
        o_tok.is_colon = (c == CH_COLON);
        o_tok.is_digit = (c >= CH_ZERO && c <= CH_NINE);
        o_tok.digit    = 4'(c - CH_ZERO);
    end

endmodule

/* rtl/core/adiftt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adiftt_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module adiftt_queue
    import adiftt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_hs  i_push,
    input  t_tok i_tok,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_tok o_tok
);

    t_tok                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_cnt < Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign do_push = i_push.valid && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

endmodule

/* rtl/core/adiftt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adiftt_back
// Tag grammar state machine and registered event output.
// ----------------------------------------------------------------------------
module adiftt_back
    import adiftt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_tok          i_tok,
    output logic          o_pop,
    adiftt_out_if.source  o_out
);

    t_phase            r_phase,   n_phase;
    logic [7:0]        r_head [3];
    logic [7:0]        n_head [3];
    logic [CNT_W-1:0]  r_name_cnt, n_name_cnt;
    logic [LEN_W-1:0]  r_len,     n_len;
    logic [LEN_W-1:0]  r_val_cnt, n_val_cnt;

    logic              r_out_valid;
    t_event            r_ev,    n_ev;
    logic [7:0]        r_ob,    n_ob;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    logic [FLEN_W-1:0] r_flen,  n_flen;

    logic [LEN_W+3:0]  len_x10;
    logic [LEN_W:0]    cnt_inc;
    logic [LEN_W+FLEN_W-1:0] len_wide;
    logic [FLEN_W-1:0] len_sat;
    logic [IDX_W-1:0]  val_idx;
    logic              is_eoh;
    logic              is_eor;

    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_ev;
    assign o_out.out_byte     = r_ob;
    assign o_out.byte_index   = r_idx;
    assign o_out.field_length = r_flen;

    assign is_eoh = (r_name_cnt == CNT_W'(3)) && r_head[0] == CH_E
                    && r_head[1] == CH_O && r_head[2] == CH_H;
    assign is_eor = (r_name_cnt == CNT_W'(3)) && r_head[0] == CH_E
                    && r_head[1] == CH_O && r_head[2] == CH_R;

    assign len_x10  = {r_len, 3'b000} + {2'b00, r_len, 1'b0} + (LEN_W+4)'(i_tok.digit);
    assign cnt_inc  = {1'b0, r_val_cnt} + 1'b1;
    assign len_wide = (LEN_W+FLEN_W)'(r_len);
    assign len_sat  = (len_wide > (LEN_W+FLEN_W)'({FLEN_W{1'b1}})) ? {FLEN_W{1'b1}}
                      : len_wide[FLEN_W-1:0];
    assign val_idx  = (r_val_cnt > LEN_W'({IDX_W{1'b1}})) ? {IDX_W{1'b1}}
                      : r_val_cnt[IDX_W-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_head     = r_head;
        n_name_cnt = r_name_cnt;
        n_len      = r_len;
        n_val_cnt  = r_val_cnt;
        n_ev       = EV_NONE;
        n_ob       = '0;
        n_idx      = '0;
        n_flen     = '0;

        unique case (r_phase)
            PH_NAME: begin
                if (i_tok.is_colon) begin
                    n_len   = '0;
                    n_phase = PH_LENGTH;
                end else if (i_tok.is_gt) begin
                    if (is_eoh || is_eor) begin
                        n_ev       = is_eoh ? EV_EOH : EV_EOR;
                        n_phase    = PH_SEARCH;
                        n_name_cnt = '0;
                        n_len      = '0;
                        n_val_cnt  = '0;
                    end else begin
                        n_ev    = EV_ERROR;
                        n_phase = PH_SKIP;
                    end
                end else if (r_name_cnt >= CNT_W'(NAME_CAP)) begin
                    n_ev       = EV_LONGNAME;
                    n_phase    = PH_SEARCH;
                    n_name_cnt = '0;
                    n_len      = '0;
                    n_val_cnt  = '0;
                end else begin
                    n_ev  = EV_NAME;
                    n_ob  = i_tok.raw;
                    n_idx = IDX_W'(r_name_cnt);
                    if (r_name_cnt < CNT_W'(3)) begin
                        n_head[r_name_cnt[1:0]] = i_tok.up;
                    end
                    n_name_cnt = r_name_cnt + 1'b1;
                end
            end
            PH_LENGTH, PH_TYPE: begin
                if (i_tok.is_gt) begin
                    n_val_cnt = '0;
                    if (r_len == '0) begin
                        n_ev       = EV_DONE;
                        n_phase    = PH_SEARCH;
                        n_name_cnt = '0;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end else if (r_phase == PH_TYPE) begin
                    n_phase = PH_TYPE;
                end else if (i_tok.is_colon) begin
                    n_phase = PH_TYPE;
                end else if (i_tok.is_digit) begin
                    n_len = (len_x10 > (LEN_W+4)'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                            : len_x10[LEN_W-1:0];
                end else begin
                    n_ev    = EV_ERROR;
                    n_phase = PH_SKIP;
                end
            end
            PH_VALUE: begin
                n_val_cnt = cnt_inc[LEN_W-1:0];
                if (cnt_inc >= {1'b0, r_len}) begin
                    n_ev       = (cnt_inc <= (LEN_W+1)'(VALUE_CAP)) ? EV_DONE : EV_DROP;
                    n_ob       = i_tok.raw;
                    n_idx      = val_idx;
                    n_flen     = len_sat;
                    n_phase    = PH_SEARCH;
                    n_name_cnt = '0;
                    n_len      = '0;
                    n_val_cnt  = '0;
                end else if (r_val_cnt < LEN_W'(VALUE_CAP)) begin
                    n_ev   = EV_VALUE;
                    n_ob   = i_tok.raw;
                    n_idx  = val_idx;
                    n_flen = len_sat;
                end
            end
            PH_SKIP: begin
                if (i_tok.is_gt) begin
                    if (is_eor) begin
                        n_ev      = EV_RESYNC;
                        n_phase   = PH_SEARCH;
                        n_len     = '0;
                        n_val_cnt = '0;
                    end
                    n_name_cnt = '0;
                end else if (i_tok.is_lt) begin
                    n_name_cnt = '0;
                end else if (r_name_cnt < CNT_W'(NAME_CAP)) begin
                    if (r_name_cnt < CNT_W'(3)) begin
                        n_head[r_name_cnt[1:0]] = i_tok.up;
                    end
                    n_name_cnt = r_name_cnt + 1'b1;
                end
            end
            default: begin
                n_phase = i_tok.is_lt ? PH_NAME : PH_SEARCH;
                if (i_tok.is_lt) begin
                    n_name_cnt = '0;
                    n_len      = '0;
                    n_val_cnt  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEARCH;
            r_head     <= '{default: '0};
            r_name_cnt <= '0;
            r_len      <= '0;
            r_val_cnt  <= '0;
        end else if (o_pop) begin
            r_phase    <= n_phase;
            r_head     <= n_head;
            r_name_cnt <= n_name_cnt;
            r_len      <= n_len;
            r_val_cnt  <= n_val_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev   <= n_ev;
            r_ob   <= n_ob;
            r_idx  <= n_idx;
            r_flen <= n_flen;
        end
    end

`ifndef SYNTHESIS
    a_name_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_cnt <= CNT_W'(NAME_CAP))
        else $error("name count beyond capacity");

    a_value_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_val_cnt < r_len))
        else $error("value count reached declared length inside value");

    a_name_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev == EV_NAME) |-> (r_idx < IDX_W'(NAME_CAP)))
        else $error("name byte index beyond capacity");

    a_value_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev == EV_VALUE) |-> (r_flen != '0))
        else $error("value word with zero field length");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped word not presented");
`endif

endmodule

/* tb/tb_adif_tag_tokenizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adif_tag_tokenizer_top
// Self-checking bench for the ADIF tag tokenizer. A short directed stream is
// followed by random records made of fields, EOR/EOH tags, broken tags with
// resync and raw noise. Each accepted byte is run through a local model of
// the tag parser. Each event word that comes out is compared field by field,
// in order, against that model. Handshake gaps on both sides vary per phase.
// ----------------------------------------------------------------------------
module tb_adif_tag_tokenizer_top
    import adiftt_pkg::*;
();

    localparam int          CYCLE_LIMIT = 200000;
    localparam int unsigned LEN_MAX     = (1 << LEN_W) - 1;
    localparam int unsigned FLEN_MAX    = (1 << FLEN_W) - 1;

    typedef struct packed {
        t_event            ev;
        logic [7:0]        ob;
        logic [IDX_W-1:0]  idx;
        logic [FLEN_W-1:0] flen;
    } t_tok_word;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic in_taken = 1'b0;

    adiftt_in_if  in_ch ();
    adiftt_out_if out_ch ();

    adif_tag_tokenizer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [7:0] pending_bytes[$];
    t_tok_word  expected_events[$];
    t_tok_word  want;
    int         n_gen = 0;
    int         n_acc = 0;
    int         n_chk = 0;
    int         n_err = 0;
    int         cycles = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         ev_count[10];

    // parser state
    t_phase      tp_phase;
    logic [7:0]  tp_head[3];
    int          tp_cnt;
    int unsigned tp_len;
    int unsigned tp_vcnt;

    function automatic void restart();
        tp_phase = PH_SEARCH;
        tp_cnt   = 0;
        tp_len   = 0;
        tp_vcnt  = 0;
    endfunction

    function automatic void track(input logic [7:0] c);
        if (tp_cnt < 3) begin
            tp_head[tp_cnt] = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFS : c;
        end
        tp_cnt++;
    endfunction

    function automatic logic is_tag(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
        return tp_cnt == 3 && tp_head[0] == a && tp_head[1] == b && tp_head[2] == c;
    endfunction

    function automatic t_tok_word tokenize_byte(input logic [7:0] c);
        t_tok_word w;
        w = '0;
        w.ev = EV_NONE;
        case (tp_phase)
            PH_NAME: begin
                if (c == CH_COLON) begin
                    tp_len   = 0;
                    tp_phase = PH_LENGTH;
                end else if (c == CH_GT) begin
                    if (is_tag(CH_E, CH_O, CH_H)) begin
                        w.ev = EV_EOH;
                        restart();
                    end else if (is_tag(CH_E, CH_O, CH_R)) begin
                        w.ev = EV_EOR;
                        restart();
                    end else begin
                        w.ev     = EV_ERROR;
                        tp_phase = PH_SKIP;
                    end
                end else if (tp_cnt >= NAME_CAP) begin
                    w.ev = EV_LONGNAME;
                    restart();
                end else begin
                    w.ev  = EV_NAME;
                    w.ob  = c;
                    w.idx = tp_cnt[IDX_W-1:0];
                    track(c);
                end
            end
            PH_LENGTH, PH_TYPE: begin
                if (c == CH_GT) begin
                    tp_vcnt = 0;
                    if (tp_len == 0) begin
                        w.ev = EV_DONE;
                        restart();
                    end else begin
                        tp_phase = PH_VALUE;
                    end
                end else if (tp_phase == PH_LENGTH) begin
                    if (c == CH_COLON) begin
                        tp_phase = PH_TYPE;
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        tp_len = tp_len * 10 + (c - CH_ZERO);
                        if (tp_len > LEN_MAX) tp_len = LEN_MAX;
                    end else begin
                        w.ev     = EV_ERROR;
                        tp_phase = PH_SKIP;
                    end
                end
            end
            PH_VALUE: begin
                w.flen = FLEN_W'((tp_len > FLEN_MAX) ? FLEN_MAX : tp_len);
                w.idx  = (tp_vcnt > 31) ? 5'd31 : tp_vcnt[IDX_W-1:0];
                if (tp_vcnt < VALUE_CAP) begin
                    w.ev = EV_VALUE;
                    w.ob = c;
                end
                tp_vcnt++;
                if (tp_vcnt >= tp_len) begin
                    w.ev = (tp_vcnt <= VALUE_CAP) ? EV_DONE : EV_DROP;
                    w.ob = c;
                    restart();
                end
                if (w.ev == EV_NONE) begin
                    w.idx  = '0;
                    w.flen = '0;
                end
            end
            PH_SKIP: begin
                if (c == CH_GT) begin
                    if (is_tag(CH_E, CH_O, CH_R)) begin
                        w.ev = EV_RESYNC;
                        restart();
                    end
                    tp_cnt = 0;
                end else if (c == CH_LT) begin
                    tp_cnt = 0;
                end else if (tp_cnt < NAME_CAP) begin
                    track(c);
                end
            end
            default: begin
                if (c == CH_LT) begin
                    restart();
                    tp_phase = PH_NAME;
                end else begin
                    tp_phase = PH_SEARCH;
                end
            end
        endcase
        return w;
    endfunction

    // ---- stimulus builders ----
    function automatic void put(input logic [7:0] b);
        pending_bytes.push_back(b);
        n_gen++;
    endfunction

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++) put(s[k]);
    endfunction

    function automatic void put_cased(input string s);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if ((c | CASE_OFS) >= CH_LO_A && (c | CASE_OFS) <= CH_LO_Z &&
                $urandom_range(0, 1) == 1) begin
                c = c ^ CASE_OFS;
            end
            put(c);
        end
    endfunction

    function automatic logic [7:0] name_char();
        string      pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";
        logic [7:0] c;
        if ($urandom_range(0, 9) != 0) return pool[$urandom_range(0, pool.len() - 1)];
        do c = 8'($urandom_range(0, 255)); while (c == CH_COLON || c == CH_GT);
        return c;
    endfunction

    function automatic void add_tag(input string s);
        put(CH_LT);
        put_cased(s);
        put(CH_GT);
    endfunction

    function automatic void add_field();
        int    nlen;
        int    vlen;
        string digits;
        put(CH_LT);
        if ($urandom_range(0, 11) == 0) begin
            put_cased($urandom_range(0, 1) ? "eor" : "eoh");
        end else begin
            case ($urandom_range(0, 9))
                7, 8:    nlen = $urandom_range(9, NAME_CAP);
                9:       nlen = $urandom_range(NAME_CAP + 1, NAME_CAP + 5);
                default: nlen = $urandom_range(0, 8);
            endcase
            repeat (nlen) put(name_char());
        end
        put(CH_COLON);
        case ($urandom_range(0, 9))
            7, 8:    vlen = $urandom_range(VALUE_CAP - 2, VALUE_CAP + 3);
            9:       vlen = $urandom_range(VALUE_CAP + 4, 45);
            default: vlen = $urandom_range(0, VALUE_CAP + 1);
        endcase
        digits = $sformatf("%0d", vlen);
        if ($urandom_range(0, 4) == 0) digits = {"00", digits};
        put_text(digits);
        if ($urandom_range(0, 2) == 0) begin
            put(CH_COLON);
            repeat ($urandom_range(0, 3)) put(name_char());
        end
        put(CH_GT);
        repeat (vlen) put(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_broken();
        string      near_miss[6] = '{"EO", "EORX", "EOHH", "XOR", "E0R", "EOT"};
        logic [7:0] bad;
        do bad = 8'($urandom_range(0, 255));
        while ((bad >= CH_ZERO && bad <= CH_NINE) || bad == CH_COLON || bad == CH_GT);
        put(CH_LT);
        case ($urandom_range(0, 3))
            0: begin
                put_cased(near_miss[$urandom_range(0, 5)]);
                put(CH_GT);
            end
            1: begin
                repeat ($urandom_range(1, 6)) put(name_char());
                put(CH_GT);
            end
            2: begin
                repeat ($urandom_range(1, 6)) put(name_char());
                put(CH_COLON);
                repeat ($urandom_range(0, 2)) put(8'(CH_ZERO + $urandom_range(0, 9)));
                put(bad);
            end
            default: begin
                // failed name EOR stays tracked, so the next '>' resyncs
                put_cased("eor");
                put(CH_COLON);
                put(bad);
                put(CH_GT);
            end
        endcase
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 1) put(CH_LT);
            repeat ($urandom_range(0, NAME_CAP + 4)) put(name_char());
            put(CH_GT);
        end
        if ($urandom_range(0, 4) != 0) add_tag("eor");
    endfunction

    function automatic void add_records(input int count);
        int stop_at;
        int pick;
        stop_at = n_gen + count;
        while (n_gen < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) add_field();
            else if (pick < 67) add_tag("eor");
            else if (pick < 72) add_tag("eoh");
            else if (pick < 90) add_broken();
            else repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
        end
    endfunction

    // ---- driver ----
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= 8'h00;
            out_ch.ready  <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (!in_ch.valid || in_taken) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= pending_bytes.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                want = tokenize_byte(in_ch.in_byte);
                expected_events.push_back(want);
                ev_count[want.ev]++;
                n_acc++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t ns: unexpected word ev=%0d byte=%02h idx=%0d len=%0d",
                             $time, out_ch.event_res, out_ch.out_byte,
                             out_ch.byte_index, out_ch.field_length);
                    n_err++;
                end else begin
                    want = expected_events.pop_front();
                    if (out_ch.event_res !== want.ev || out_ch.out_byte !== want.ob ||
                        out_ch.byte_index !== want.idx ||
                        out_ch.field_length !== want.flen) begin
                        $display({"%0t ns: word %0d expected ev=%0d byte=%02h idx=%0d len=%0d",
                                  ", got ev=%0d byte=%02h idx=%0d len=%0d"},
                                 $time, n_chk, want.ev, want.ob, want.idx, want.flen,
                                 out_ch.event_res, out_ch.out_byte, out_ch.byte_index,
                                 out_ch.field_length);
                        n_err++;
                    end
                    n_chk++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d of %0d words checked",
                     $time, cycles, n_chk, n_acc);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        foreach (ev_count[k]) ev_count[k] = 0;
        tp_head = '{8'h00, 8'h00, 8'h00};
        restart();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: EOH in mixed case, zero length, typed one-byte value,
        // bare tag into skip, resync on EOR
        put(8'h00);
        put_text("<eOh>");
        put_text("<A:0>");
        put_text("<B:1:N>");
        put(8'hFF);
        put_text("<x>");
        put_text("<eor>");

        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 66 : 0;
            snk_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 34 : 0;
            add_records(220);
            if (mode == 2) begin
                // saturating length; the stream ends inside this value
                put_text("<sat:99999:S>");
                repeat (40) put(8'($urandom_range(0, 255)));
            end
            wait (n_acc == n_gen);
            wait (n_chk == n_acc);
        end

        repeat (8) @(posedge i_clk);
        if (expected_events.size() != 0) begin
            $display("%0t ns: %0d expected words never arrived", $time,
                     expected_events.size());
            n_err++;
        end
        $display("Tokenized %0d bytes, %0d event words checked, %0d mismatches.",
                 n_acc, n_chk, n_err);
        $display({"Events: name %0d, value %0d, done %0d, dropped %0d, EOR %0d, EOH %0d,",
                  " error %0d, resync %0d, long name %0d"},
                 ev_count[EV_NAME], ev_count[EV_VALUE], ev_count[EV_DONE],
                 ev_count[EV_DROP], ev_count[EV_EOR], ev_count[EV_EOH],
                 ev_count[EV_ERROR], ev_count[EV_RESYNC], ev_count[EV_LONGNAME]);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
